// ----- sv/ascii_speed_command_parser_unit_assert.svh -----
// Assertion macros for the ASCII speed command parser.
// Depends on nothing; included by the top level only.
`ifndef ASCII_SPEED_COMMAND_PARSER_UNIT_ASSERT_SVH
`define ASCII_SPEED_COMMAND_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ascp_pkg.sv -----
// Shared types and constants of the ASCII speed command parser.
// No dependencies; imported by the frame, decode and top-level modules.
package ascp_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t CH_START = 8'h23; // '#'
	localparam byte_t CH_END   = 8'h2E; // '.'
	localparam byte_t CH_SPEED = 8'h53; // 'S'
	localparam byte_t CH_DIGIT = 8'h44; // 'D'
	localparam byte_t CH_RAW   = 8'h47; // 'G'
	localparam byte_t CH_MINUS = 8'h2D; // '-'
	localparam byte_t CH_ZERO  = 8'h30; // '0'

	// Decode reads positions 1 (letter), 2 (sign/argument), 3..7 (digits).
	localparam int DIGITS   = 5;
	localparam int LAST_POS = 7;

	localparam int SUM_W   = 23; // holds 11111 * (-48 .. 207) and its negation
	localparam int LIMIT_W = 15;
	localparam int SPEED_W = 16;

	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 15'd25000;

	localparam logic signed [SUM_W-1:0] WEIGHT [DIGITS] = '{
		23'sd10000, 23'sd1000, 23'sd100, 23'sd10, 23'sd1
	};

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SPEED,
		KIND_DIGIT,
		KIND_RAW
	} cmd_kind_t;

	// Snapshot of the frame positions that the decode looks at.
	// digit[0] is position 3, the most significant digit.
	typedef struct packed {
		byte_t                   cmd;
		byte_t                   arg;
		byte_t [DIGITS-1:0]      digit;
	} frame_view_t;

	// Decoded frame held between the decode stage and the clamp.
	typedef struct packed {
		cmd_kind_t               kind;
		logic                    negate;
		logic signed [SUM_W-1:0] sum;
		byte_t                   test_value;
		logic                    overflow;
	} decode_t;

	// (b - '0') * weight; the byte is not checked for being a digit.
	function automatic logic signed [SUM_W-1:0] digit_term(
		input byte_t                   b,
		input logic signed [SUM_W-1:0] w
	);
		logic signed [SUM_W-1:0] v;
		v = $signed({{(SUM_W-8){1'b0}}, b}) - $signed({{(SUM_W-8){1'b0}}, CH_ZERO});
		return v * w;
	endfunction

endpackage

// ----- sv/ascp_rx_if.sv -----
// Receive channel of the ASCII speed command parser: one UART byte per beat.
// No dependencies.
interface ascp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_error;

	modport source (output valid, rx_byte, rx_error, input ready);
	modport sink   (input valid, rx_byte, rx_error, output ready);
endinterface

// ----- sv/ascp_cmd_if.sv -----
// Command channel of the ASCII speed command parser: one decoded frame per beat.
// No dependencies.
interface ascp_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd_kind;
	logic [15:0] speed;
	logic [7:0]  test_value;
	logic        overflow_error;

	modport source (output valid, cmd_kind, speed, test_value, overflow_error, input ready);
	modport sink   (input valid, cmd_kind, speed, test_value, overflow_error, output ready);
endinterface

// ----- sv/ascp_frame.sv -----
// Frame collector: write position, sticky overflow and the stored positions
// that the decode reads. Depends on ascp_pkg.
module ascp_frame import ascp_pkg::*; #(
	parameter int FRAME_LIMIT = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  byte_t       rx_byte,
	output frame_view_t view,
	output logic        overflow
);

	localparam int POS_W = $clog2(FRAME_LIMIT + 1);

	logic [POS_W-1:0] wpos_q;
	logic             ovf_q;
	byte_t            slot_q [1:LAST_POS];
	logic [POS_W:0]   wpos_inc;
	logic             sat;

	assign wpos_inc = {1'b0, wpos_q} + {{POS_W{1'b0}}, 1'b1};
	assign sat      = (wpos_inc >= (POS_W+1)'(FRAME_LIMIT));

	// Position 0 and positions past LAST_POS are written but never read,
	// so only positions 1..LAST_POS are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			ovf_q  <= 1'b0;
			for (int i = 1; i <= LAST_POS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (upd) begin
			if (rx_byte == CH_START) begin
				wpos_q <= POS_W'(1);
			end else if (rx_byte != CH_END) begin
				for (int i = 1; i <= LAST_POS; i++) begin
					if (wpos_q == POS_W'(i)) begin
						slot_q[i] <= rx_byte;
					end
				end
				if (sat) begin
					wpos_q <= POS_W'(FRAME_LIMIT);
					ovf_q  <= 1'b1;
				end else begin
					wpos_q <= wpos_inc[POS_W-1:0];
				end
			end
		end
	end

	always_comb begin
		view.cmd = slot_q[1];
		view.arg = slot_q[2];
		for (int i = 0; i < DIGITS; i++) begin
			view.digit[i] = slot_q[3 + i];
		end
	end

	assign overflow = ovf_q;

endmodule

// ----- sv/ascp_decode.sv -----
// Decode stage: command letter, test value and weighted digit sum of a
// completed frame, registered. Depends on ascp_pkg.
module ascp_decode import ascp_pkg::*; (
	input  logic        clk,
	input  logic        ld,
	input  frame_view_t view,
	input  logic        overflow,
	output decode_t     dec_s2
);

	decode_t                 dec;
	logic signed [SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < DIGITS; i++) begin
			sum = sum + digit_term(view.digit[i], WEIGHT[i]);
		end
	end

	always_comb begin
		dec.negate     = (view.arg == CH_MINUS);
		dec.sum        = sum;
		dec.overflow   = overflow;
		dec.test_value = '0;
		unique case (view.cmd)
			CH_SPEED: dec.kind = KIND_SPEED;
			CH_DIGIT: begin
				dec.kind       = KIND_DIGIT;
				dec.test_value = view.arg - CH_ZERO;
			end
			CH_RAW: begin
				dec.kind       = KIND_RAW;
				dec.test_value = view.arg;
			end
			default: dec.kind = KIND_NONE;
		endcase
	end

	// Payload only; the valid bit lives in the top level.
	always_ff @(posedge clk) begin
		if (ld) begin
			dec_s2 <= dec;
		end
	end

endmodule

// ----- sv/ascii_speed_command_parser_unit.sv -----
// Top level of the ASCII speed command parser: input register, frame
// collector, decode stage, clamp and result register. Depends on ascp_pkg,
// ascp_rx_if, ascp_cmd_if, ascp_frame, ascp_decode and the assertion header.
//
//  Port     | Dir  | Beat carries
//  ---------+------+-------------------------------------------------------
//  rx       | in   | rx_byte, rx_error: one received UART byte
//  cmd      | out  | cmd_kind, speed, test_value, overflow_error: one frame
//  cfg_*    | in   | cfg_wdata: speed_limit, written when cfg_we is high
//
//  One byte is taken per cycle while rx.ready is high; a '.' passes the
//  input register, the decode register and the result register before
//  its beat shows up on cmd.
//  Other bytes only update the frame and give no beat.
//  Reset (arst_n low) empties the pipeline, clears the frame and the
//  overflow flag and loads speed_limit with 25000.
//  A stalled cmd holds the result register; bytes other than '.' keep
//  flowing into the frame, the next '.' waits in the decode register, and
//  rx.ready drops once another byte waits behind it in the input register.

`include "ascii_speed_command_parser_unit_assert.svh"

module ascii_speed_command_parser_unit import ascp_pkg::*; #(
	parameter int FRAME_LIMIT = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	ascp_rx_if.sink            rx,
	ascp_cmd_if.source         cmd,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;
	logic  err_s1;

	// Decode register.
	logic    valid_s2;
	decode_t dec_s2;

	// Result register.
	logic                 out_valid_q;
	cmd_kind_t            kind_q;
	logic [SPEED_W-1:0]   speed_q;
	byte_t                tv_q;
	logic                 ovf_q;

	logic [LIMIT_W-1:0]   limit_q;

	logic out_ld, s2_free, s1_free, s1_ok, s1_end;

	frame_view_t view;
	logic        frame_ovf;

	logic signed [SUM_W-1:0] signed_sum;
	logic signed [SUM_W-1:0] lim;
	logic signed [SUM_W-1:0] clamped;
	logic [SPEED_W-1:0]      speed_d;

	// Each stage advances when the stage after it is empty or advancing.
	assign out_ld  = !out_valid_q || cmd.ready;
	assign s2_free = !valid_s2 || out_ld;
	assign s1_free = !valid_s1 || s2_free;
	assign rx.ready = s1_free;

	// Drop bytes with a line error; only a clean '.' makes a result.
	assign s1_ok  = valid_s1 && s2_free && !err_s1;
	assign s1_end = s1_ok && (byte_s1 == CH_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			err_s1  <= rx.rx_error;
		end
	end

	ascp_frame #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (s1_ok),
		.rx_byte  (byte_s1),
		.view     (view),
		.overflow (frame_ovf)
	);

	ascp_decode u_decode (
		.clk      (clk),
		.ld       (s1_end),
		.view     (view),
		.overflow (frame_ovf),
		.dec_s2   (dec_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_end;
		end
	end

	// Apply the sign, then clamp to +/- speed_limit.
	always_comb begin
		signed_sum = dec_s2.negate ? -dec_s2.sum : dec_s2.sum;
		lim        = $signed({{(SUM_W-LIMIT_W){1'b0}}, limit_q});
		priority if (signed_sum > lim) begin
			clamped = lim;
		end else if (signed_sum < -lim) begin
			clamped = -lim;
		end else begin
			clamped = signed_sum;
		end
		speed_d = (dec_s2.kind == KIND_SPEED) ? clamped[SPEED_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && valid_s2) begin
			kind_q  <= dec_s2.kind;
			speed_q <= speed_d;
			tv_q    <= dec_s2.test_value;
			ovf_q   <= dec_s2.overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SPEED_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign cmd.valid          = out_valid_q;
	assign cmd.cmd_kind       = kind_q;
	assign cmd.speed          = speed_q;
	assign cmd.test_value     = tv_q;
	assign cmd.overflow_error = ovf_q;

	// A clean '.' always lands in the decode register on the next edge.
	`ASCP_ASSERT_NEXT(a_end_reaches_s2, clk, arst_n, s1_end, valid_s2,
		"end byte lost before decode")
	// Overflow never clears once set.
	`ASCP_ASSERT_NEXT(a_overflow_sticky, clk, arst_n, frame_ovf, frame_ovf,
		"overflow flag cleared")
	// Only a speed command carries a speed.
	`ASCP_ASSERT_NOW(a_speed_only_for_s, clk, arst_n,
		cmd.valid && (cmd.cmd_kind != KIND_SPEED), cmd.speed == '0,
		"speed set on non-speed result")

endmodule
